@@ design/dtsi_pkg.sv @@
package dtsi_pkg;

  typedef enum logic [2:0] {
    OP_READ  = 3'd0,
    OP_WRITE = 3'd1,
    OP_TICK  = 3'd2,
    OP_CNT   = 3'd3,
    OP_FLAG  = 3'd4,
    OP_SP    = 3'd5
  } op_e;

  localparam logic [3:0] REG_PRA   = 4'h0;
  localparam logic [3:0] REG_PRB   = 4'h1;
  localparam logic [3:0] REG_DIRA  = 4'h2;
  localparam logic [3:0] REG_DIRB  = 4'h3;
  localparam logic [3:0] REG_TALO  = 4'h4;
  localparam logic [3:0] REG_TAHI  = 4'h5;
  localparam logic [3:0] REG_TBLO  = 4'h6;
  localparam logic [3:0] REG_TBHI  = 4'h7;
  localparam logic [3:0] REG_TOD10 = 4'h8;
  localparam logic [3:0] REG_TODS  = 4'h9;
  localparam logic [3:0] REG_TODM  = 4'hA;
  localparam logic [3:0] REG_TODH  = 4'hB;
  localparam logic [3:0] REG_SDR   = 4'hC;
  localparam logic [3:0] REG_ICR   = 4'hD;
  localparam logic [3:0] REG_CRA   = 4'hE;
  localparam logic [3:0] REG_CRB   = 4'hF;

  localparam logic [19:0] DIV_RESET = 20'd16420;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  reg_address;
    logic [7:0]  write_data;
    logic        pin_level;
    logic [7:0]  pins_a;
    logic [7:0]  pins_b;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_out;
    logic [7:0] port_a_drive;
    logic [7:0] port_b_drive;
    logic       sp_out;
  } out_item_t;

  typedef struct packed {
    logic [15:0] count;
    logic [15:0] reload;
    logic [7:0]  ctrl;
    logic        run;
    logic        pulse;
    logic        toggle;
    logic        under;
    logic [1:0]  load_phase;
    logic        skip_dec;
  } tmr_t;

  function automatic logic [7:0] bcd_next(logic [7:0] v, logic [7:0] lim);
    logic [4:0] lo;
    logic [3:0] hi;
    if (v == lim) return 8'h00;
    hi = v[7:4];
    lo = {1'b0, v[3:0]};
    if (lo == 5'd9) return {hi + 4'd1, 4'h0};
    lo = lo + 5'd1;
    return {hi, 4'h0} | {3'b000, lo};
  endfunction

  function automatic logic [7:0] hour_next(logic [7:0] hr);
    logic       ap;
    logic [4:0] lo;
    logic [1:0] hi;
    logic [5:0] h;
    ap = hr[7];
    hi = {1'b0, hr[4]};
    lo = {1'b0, hr[3:0]};
    if (lo == 5'd9) begin
      hi = hi + 2'd1;
      h = {hi, 4'h0};
    end else begin
      lo = lo + 5'd1;
      h = {hi, 4'h0} | {1'b0, lo};
    end
    if (h == 6'h12) ap = ~ap;
    else if (h == 6'h13) h = 6'h01;
    return {ap, 2'b00, h[4:0]};
  endfunction

  function automatic logic [7:0] port_b_out(logic [7:0] latch, tmr_t ta, tmr_t tb);
    logic [7:0] v;
    v = latch;
    if (ta.ctrl[1]) v[6] = ta.ctrl[2] ? ta.toggle : ta.pulse;
    if (tb.ctrl[1]) v[7] = tb.ctrl[2] ? tb.toggle : tb.pulse;
    return v;
  endfunction

endpackage

@@ design/dtsi_chan_if.sv @@
interface dtsi_chan_if #(parameter int unsigned W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/dual_timer_tod_serial_interface.sv @@
// Two-port interface adapter with two 16-bit timers, BCD time-of-day clock
// with alarm, serial shifter and masked interrupt latch.
// Channels:
//   in_if  : one item per transfer (read, write, tick, CNT level, FLAG edge,
//            SP level) with port pin levels.
//   out_if : one result per item: read data, irq pin, port drives, SP level.
//   cfg_if : 20-bit time-of-day divider reload; write only while idle.
// Each item is processed in the cycle it is accepted; its result is
// registered and shown the next cycle. One item per cycle is sustained
// while the receiver takes each result. in_if.ready is high whenever the
// result register is empty or being drained, so a stalled receiver holds
// the result and blocks further items.
// Reset (rst_ni low) sets timer counts/reloads to 0xFFFF, TOD phase to six,
// the divider to 16420 and clears ports, shifter and interrupt state.
module dual_timer_tod_serial_interface (
  input  logic         clk_i,
  input  logic         rst_ni,
  dtsi_chan_if.sink    in_if,
  dtsi_chan_if.source  out_if,
  dtsi_chan_if.sink    cfg_if
);

  dtsi_pkg::tmr_t tm_q [2];
  dtsi_pkg::tmr_t tm_d [2];
  logic [7:0]  port_latch_q [2], port_latch_d [2];
  logic [7:0]  port_dir_q [2], port_dir_d [2];
  logic [7:0]  clk_dig_q [4], clk_dig_d [4];
  logic [7:0]  alm_dig_q [4], alm_dig_d [4];
  logic [7:0]  snap_q [4], snap_d [4];
  logic [7:0]  stage_q [3], stage_d [3];
  logic        snap_held_q, snap_held_d, frozen_q, frozen_d;
  logic [19:0] div_reload_q, tick_div_q, tick_div_d;
  logic [2:0]  phase_q, phase_d, phase_rl_q, phase_rl_d;
  logic [7:0]  sr_q, sr_d, sdr_q, sdr_d;
  logic [3:0]  bitcnt_q, bitcnt_d;
  logic        sh_out_q, sh_out_d, sh_busy_q, sh_busy_d, sh_clk_q, sh_clk_d;
  logic        sh_pend_q, sh_pend_d, sp_q, sp_d;
  logic [4:0]  icr_q, icr_d, mask_q, mask_d;
  logic        irq_line_q, irq_line_d, irq_pin_q, irq_pin_d, cnt_last_q, cnt_last_d;
  logic        out_valid_q;
  dtsi_pkg::out_item_t out_q, out_d;
  dtsi_pkg::in_item_t  it;
  logic        accept;
  logic [7:0]  rd;

  assign it = in_if.data;
  assign in_if.ready = !out_valid_q || out_if.ready;
  assign accept = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_q;
  assign out_if.data = out_q;

  always_comb begin
    logic [4:0]  raise;
    logic        tcnt [2];
    logic        was_run, was_out;
    logic [7:0]  v, old;
    logic [1:0]  k;
    logic        alarm, rising;
    logic        ti;
    int          i;
    raise = '0;
    tcnt[0] = 1'b0;
    tcnt[1] = 1'b0;
    rd = '0;
    v = it.write_data;
    old = '0;
    k = '0;
    ti = 1'b0;
    i = 0;
    was_run = 1'b0;
    was_out = 1'b0;
    rising = 1'b0;
    alarm = tm_q[1].ctrl[7];
    tm_d = tm_q;
    port_latch_d = port_latch_q;
    port_dir_d = port_dir_q;
    clk_dig_d = clk_dig_q;
    alm_dig_d = alm_dig_q;
    snap_d = snap_q;
    stage_d = stage_q;
    snap_held_d = snap_held_q;
    frozen_d = frozen_q;
    tick_div_d = tick_div_q;
    phase_d = phase_q;
    phase_rl_d = phase_rl_q;
    sr_d = sr_q;
    sdr_d = sdr_q;
    bitcnt_d = bitcnt_q;
    sh_out_d = sh_out_q;
    sh_busy_d = sh_busy_q;
    sh_clk_d = sh_clk_q;
    sh_pend_d = sh_pend_q;
    sp_d = sp_q;
    icr_d = icr_q;
    mask_d = mask_q;
    irq_line_d = irq_line_q;
    irq_pin_d = irq_pin_q;
    cnt_last_d = cnt_last_q;

    case (it.opcode)
      dtsi_pkg::OP_READ: begin
        case (it.reg_address)
          dtsi_pkg::REG_PRA:
            rd = (port_latch_q[0] & port_dir_q[0]) | (it.pins_a & ~port_dir_q[0]);
          dtsi_pkg::REG_PRB:
            rd = (dtsi_pkg::port_b_out(port_latch_q[1], tm_q[0], tm_q[1]) & port_dir_q[1])
                 | (it.pins_b & ~port_dir_q[1]);
          dtsi_pkg::REG_DIRA: rd = port_dir_q[0];
          dtsi_pkg::REG_DIRB: rd = port_dir_q[1];
          dtsi_pkg::REG_TALO: rd = tm_q[0].count[7:0];
          dtsi_pkg::REG_TAHI: rd = tm_q[0].count[15:8];
          dtsi_pkg::REG_TBLO: rd = tm_q[1].count[7:0];
          dtsi_pkg::REG_TBHI: rd = tm_q[1].count[15:8];
          dtsi_pkg::REG_TOD10: begin
            rd = snap_held_q ? snap_q[0] : clk_dig_q[0];
            snap_held_d = 1'b0;
          end
          dtsi_pkg::REG_TODS: rd = snap_held_q ? snap_q[1] : clk_dig_q[1];
          dtsi_pkg::REG_TODM: rd = snap_held_q ? snap_q[2] : clk_dig_q[2];
          dtsi_pkg::REG_TODH: begin
            if (!snap_held_q) begin
              snap_held_d = 1'b1;
              snap_d = clk_dig_q;
              rd = clk_dig_q[3];
            end else begin
              rd = snap_q[3];
            end
          end
          dtsi_pkg::REG_SDR: rd = sdr_q;
          dtsi_pkg::REG_ICR: begin
            rd = {irq_line_q, 2'b00, icr_q};
            icr_d = '0;
            irq_line_d = 1'b0;
            irq_pin_d = 1'b0;
          end
          dtsi_pkg::REG_CRA: rd = tm_q[0].ctrl;
          default: rd = tm_q[1].ctrl;
        endcase
      end
      dtsi_pkg::OP_WRITE: begin
        case (it.reg_address)
          dtsi_pkg::REG_PRA: port_latch_d[0] = v;
          dtsi_pkg::REG_PRB: port_latch_d[1] = v;
          dtsi_pkg::REG_DIRA: port_dir_d[0] = v;
          dtsi_pkg::REG_DIRB: port_dir_d[1] = v;
          dtsi_pkg::REG_TALO, dtsi_pkg::REG_TBLO: begin
            ti = it.reg_address[1];
            tm_d[ti].reload[7:0] = v;
          end
          dtsi_pkg::REG_TAHI, dtsi_pkg::REG_TBHI: begin
            ti = it.reg_address[1];
            tm_d[ti].reload[15:8] = v;
            if (!tm_q[ti].run) tm_d[ti].count = {v, tm_q[ti].reload[7:0]};
          end
          dtsi_pkg::REG_TOD10: begin
            if (alarm) begin
              alm_dig_d[0] = {4'h0, v[3:0]};
            end else begin
              clk_dig_d[0] = {4'h0, v[3:0]};
              if (frozen_q) begin
                clk_dig_d[1] = stage_q[0];
                clk_dig_d[2] = stage_q[1];
                clk_dig_d[3] = stage_q[2];
                frozen_d = 1'b0;
              end
              tick_div_d = div_reload_q;
              phase_d = phase_rl_q;
            end
          end
          dtsi_pkg::REG_TODS, dtsi_pkg::REG_TODM: begin
            k = it.reg_address[1:0];
            if (alarm) alm_dig_d[k] = {1'b0, v[6:0]};
            else if (frozen_q) stage_d[k - 2'd1] = {1'b0, v[6:0]};
            else clk_dig_d[k] = {1'b0, v[6:0]};
          end
          dtsi_pkg::REG_TODH: begin
            if (alarm) begin
              alm_dig_d[3] = v & 8'h9F;
            end else begin
              frozen_d = 1'b1;
              stage_d[2] = v & 8'h9F;
              stage_d[0] = clk_dig_q[1];
              stage_d[1] = clk_dig_q[2];
            end
          end
          dtsi_pkg::REG_SDR: begin
            sdr_d = v;
            if (sh_out_q) begin
              if (sh_busy_q) begin
                sh_pend_d = 1'b1;
              end else begin
                sr_d = v;
                sh_busy_d = 1'b1;
                bitcnt_d = '0;
              end
            end
          end
          dtsi_pkg::REG_ICR: begin
            if (v[7]) mask_d = mask_q | v[4:0];
            else mask_d = mask_q & ~v[4:0];
          end
          default: begin
            ti = it.reg_address[0];
            was_run = tm_q[ti].run;
            old = tm_q[ti].ctrl;
            if (v[4]) tm_d[ti].load_phase = 2'd3;
            v[4] = 1'b0;
            tm_d[ti].ctrl = v;
            tm_d[ti].run = v[0];
            if (!ti) begin
              was_out = sh_out_q;
              if (old[7] != v[7]) begin
                phase_rl_d = v[7] ? 3'd5 : 3'd6;
                phase_d = v[7] ? 3'd5 : 3'd6;
              end
              sh_out_d = v[6];
              if (was_out && !v[6]) begin
                sh_busy_d = 1'b0;
                sh_pend_d = 1'b0;
                sh_clk_d = 1'b0;
                bitcnt_d = '0;
                sp_d = 1'b1;
              end
            end
            if (!was_run && v[0] && tm_d[ti].load_phase == 2'd0) begin
              if (tm_q[ti].count == 16'h0000) tm_d[ti].count = tm_q[ti].reload;
              tm_d[ti].skip_dec = 1'b1;
            end
          end
        endcase
      end
      dtsi_pkg::OP_TICK, dtsi_pkg::OP_CNT: begin
        if (it.opcode == dtsi_pkg::OP_TICK) begin
          irq_pin_d = irq_line_q;
          tcnt[0] = !tm_q[0].ctrl[5];
        end else begin
          rising = !cnt_last_q && it.pin_level;
          cnt_last_d = it.pin_level;
          tcnt[0] = rising && tm_q[0].ctrl[5] && tm_q[0].run;
        end
        for (i = 0; i < 2; i++) begin
          if (i == 1) begin
            if (it.opcode == dtsi_pkg::OP_TICK) begin
              case (tm_q[1].ctrl[6:5])
                2'b00: tcnt[1] = 1'b1;
                2'b10: tcnt[1] = tm_d[0].under;
                2'b11: tcnt[1] = tm_d[0].under && cnt_last_q;
                default: tcnt[1] = 1'b0;
              endcase
            end else begin
              tcnt[1] = rising && tm_q[1].ctrl[6:5] == 2'b01 && tm_q[1].run;
            end
          end
          if (it.opcode == dtsi_pkg::OP_TICK || tcnt[i]) begin
            tm_d[i].pulse = 1'b0;
            tm_d[i].under = 1'b0;
            if (tm_q[i].load_phase != 2'd0) begin
              tm_d[i].load_phase = tm_q[i].load_phase - 2'd1;
              if (tm_q[i].load_phase == 2'd1) tm_d[i].count = tm_q[i].reload;
              tm_d[i].skip_dec = 1'b0;
            end else if (tm_q[i].skip_dec) begin
              tm_d[i].skip_dec = 1'b0;
            end else if (tm_q[i].run && tcnt[i]) begin
              if (tm_q[i].count == 16'h0000) begin
                tm_d[i].under = 1'b1;
                tm_d[i].count = tm_q[i].reload;
                if (tm_q[i].ctrl[1]) begin
                  if (tm_q[i].ctrl[2]) tm_d[i].toggle = !tm_q[i].toggle;
                  else tm_d[i].pulse = 1'b1;
                end
                raise[i] = 1'b1;
                if (tm_q[i].ctrl[3]) begin
                  tm_d[i].ctrl[0] = 1'b0;
                  tm_d[i].run = 1'b0;
                end
              end else begin
                tm_d[i].count = tm_q[i].count - 16'd1;
              end
            end
          end
        end
        if (it.opcode == dtsi_pkg::OP_TICK) begin
          if (tm_d[0].under && sh_out_q) begin
            sh_clk_d = !sh_clk_q;
            if (!sh_clk_q && (sh_busy_q || sh_pend_q)) begin
              sr_d = sh_busy_q ? sr_q : sdr_q;
              bitcnt_d = sh_busy_q ? bitcnt_q : 4'd0;
              sh_pend_d = sh_busy_q ? sh_pend_q : 1'b0;
              sp_d = sr_d[7];
              sr_d = {sr_d[6:0], 1'b0};
              bitcnt_d = bitcnt_d + 4'd1;
              sh_busy_d = 1'b1;
              if (bitcnt_d >= 4'd8) begin
                sh_busy_d = 1'b0;
                bitcnt_d = '0;
                raise[3] = 1'b1;
              end
            end
          end
          if (div_reload_q != '0 && !frozen_q) begin
            tick_div_d = tick_div_q - 20'd1;
            if (tick_div_d == '0) begin
              tick_div_d = div_reload_q;
              if (phase_rl_q != '0) begin
                phase_d = phase_q - 3'd1;
                if (phase_d == '0) begin
                  phase_d = phase_rl_q;
                  clk_dig_d[0] = dtsi_pkg::bcd_next(clk_dig_q[0], 8'h09);
                  if (clk_dig_d[0] == '0) begin
                    clk_dig_d[1] = dtsi_pkg::bcd_next(clk_dig_q[1], 8'h59);
                    if (clk_dig_d[1] == '0) begin
                      clk_dig_d[2] = dtsi_pkg::bcd_next(clk_dig_q[2], 8'h59);
                      if (clk_dig_d[2] == '0) clk_dig_d[3] = dtsi_pkg::hour_next(clk_dig_q[3]);
                    end
                  end
                  if (clk_dig_d == alm_dig_q) raise[2] = 1'b1;
                end
              end
            end
          end
        end else if (rising && !sh_out_q) begin
          sr_d = {sr_q[6:0], sp_q};
          bitcnt_d = bitcnt_q + 4'd1;
          if (bitcnt_d >= 4'd8) begin
            bitcnt_d = '0;
            sdr_d = sr_d;
            raise[3] = 1'b1;
          end
        end
      end
      dtsi_pkg::OP_FLAG: raise[4] = 1'b1;
      dtsi_pkg::OP_SP: sp_d = it.pin_level;
      default: ;
    endcase
    icr_d = icr_d | raise;
    if ((raise & mask_q) != '0) irq_line_d = 1'b1;

    out_d.read_data = rd;
    out_d.irq_out = irq_pin_d;
    out_d.port_a_drive = port_latch_d[0];
    out_d.port_b_drive = dtsi_pkg::port_b_out(port_latch_d[1], tm_d[0], tm_d[1]);
    out_d.sp_out = sp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        tm_q[i] <= '{count: 16'hFFFF, reload: 16'hFFFF, default: '0};
        port_latch_q[i] <= '0;
        port_dir_q[i] <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        clk_dig_q[i] <= '0;
        alm_dig_q[i] <= '0;
        snap_q[i] <= '0;
      end
      for (int i = 0; i < 3; i++) stage_q[i] <= '0;
      snap_held_q <= 1'b0;
      frozen_q <= 1'b0;
      div_reload_q <= dtsi_pkg::DIV_RESET;
      tick_div_q <= dtsi_pkg::DIV_RESET;
      phase_q <= 3'd6;
      phase_rl_q <= 3'd6;
      sr_q <= '0;
      sdr_q <= '0;
      bitcnt_q <= '0;
      sh_out_q <= 1'b0;
      sh_busy_q <= 1'b0;
      sh_clk_q <= 1'b0;
      sh_pend_q <= 1'b0;
      sp_q <= 1'b0;
      icr_q <= '0;
      mask_q <= '0;
      irq_line_q <= 1'b0;
      irq_pin_q <= 1'b0;
      cnt_last_q <= 1'b1;
      out_valid_q <= 1'b0;
      out_q <= '0;
    end else begin
      if (cfg_if.valid) div_reload_q <= cfg_if.data;
      if (accept) begin
        tm_q <= tm_d;
        port_latch_q <= port_latch_d;
        port_dir_q <= port_dir_d;
        clk_dig_q <= clk_dig_d;
        alm_dig_q <= alm_dig_d;
        snap_q <= snap_d;
        stage_q <= stage_d;
        snap_held_q <= snap_held_d;
        frozen_q <= frozen_d;
        tick_div_q <= tick_div_d;
        phase_q <= phase_d;
        phase_rl_q <= phase_rl_d;
        sr_q <= sr_d;
        sdr_q <= sdr_d;
        bitcnt_q <= bitcnt_d;
        sh_out_q <= sh_out_d;
        sh_busy_q <= sh_busy_d;
        sh_clk_q <= sh_clk_d;
        sh_pend_q <= sh_pend_d;
        sp_q <= sp_d;
        icr_q <= icr_d;
        mask_q <= mask_d;
        irq_line_q <= irq_line_d;
        irq_pin_q <= irq_pin_d;
        cnt_last_q <= cnt_last_d;
        out_q <= out_d;
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_if.ready |=> out_valid_q && $stable(out_q))
    else $error("result changed while stalled");
  a_icr_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && it.opcode == dtsi_pkg::OP_READ && it.reg_address == dtsi_pkg::REG_ICR
    |=> !irq_pin_q && !irq_line_q && icr_q == '0)
    else $error("interrupt read did not clear");
  a_bitcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bitcnt_q < 4'd8)
    else $error("shift count out of range");
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_rl_q == 3'd5 || phase_rl_q == 3'd6)
    else $error("bad tod phase reload");

endmodule
